@@ src/multilevel_feedback_scheduler_core_assert.svh @@
// Assertion macros shared by the scheduler modules.
// Each macro expects clock aclk and active-low reset aresetn in scope.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_CORE_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_CORE_ASSERT_SVH

// Condition holds at every rising clock edge outside reset
`define MFS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define MFS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define MFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mfs_pkg.sv @@
// ----------------------------------------------------------------------------
// mfs_pkg
// Types and fixed constants of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfs_pkg;

    localparam int ID_W    = 8;
    localparam int TIME_W  = 12;
    localparam int CNT_W   = 8;
    localparam int BQ_W    = 8;
    localparam int LU_W    = 2;
    localparam int STIME_W = 32;
    localparam int LVL_OUT_W = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 96;

    localparam logic [BQ_W-1:0]  BQ_RESET = 8'd20;
    localparam logic [LU_W-1:0]  LU_RESET = 2'd3;
    localparam logic [CNT_W-1:0] CNT_MAX  = 8'd255;

    // Item kinds carried in s_tuser
    localparam logic KIND_ADMIT    = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    // Configuration register indexes
    localparam logic REG_BASE_QUANTUM  = 1'b0;
    localparam logic REG_LEVELS_IN_USE = 1'b1;

    // One queue entry, id in the low bits
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [TIME_W-1:0] run;
        logic [TIME_W-1:0] need;
        logic [ID_W-1:0]   id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Result item, accepted in the lowest bit
    typedef struct packed {
        logic                 all_idle;
        logic                 finished;
        logic [CNT_W-1:0]     slice_count;
        logic [TIME_W-1:0]    total_run;
        logic [TIME_W-1:0]    time_left;
        logic [TIME_W-1:0]    slice_used;
        logic [STIME_W-1:0]   slice_start;
        logic [LVL_OUT_W-1:0] served_level;
        logic [ID_W-1:0]      served_id;
        logic                 accepted;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the input transaction, launch the queue read
        logic commit;  // apply the item to the queues and load the result
    } mfs_cmd_t;

endpackage

@@ src/multilevel_feedback_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_core
// Multilevel feedback queue scheduler: admits processes into level 0 and
// dispatches time slices from the lowest-numbered non-empty level, demoting
// unfinished processes.
//
// Channel  Dir  Ports                             Contents
// s_       in   s_tvalid s_tready s_tdata s_tuser admit / dispatch item
// m_       out  m_tvalid m_tready m_tdata         one result per item
// cfg_     in   cfg_wr_en cfg_index cfg_wdata     base_quantum, levels_in_use
//
// Each item is handled as an accept plus queue RAM read, then the
// read-modify-write commit into the queue RAM and the result register.
// A new item is accepted while the previous result still waits on m_.
// The commit waits while the result register is full and m_tready is low.
// Reset (aresetn, synchronous) empties all levels at once; no clearing pass.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_core
    import mfs_pkg::*;
#(
    parameter int LEVELS    = 3,
    parameter int MAX_PROCS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // proc_id[7:0], service time[19:8], zero pad
    input  logic                 s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // accepted[0], served_id[8:1], served_level[10:9], slice_start[42:11],
    // slice_used[54:43], time_left[66:55], total_run[78:67], slice_count[86:79],
    // finished[87], all_idle[88], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [BQ_W-1:0]      cfg_wdata
);

    mfs_cmd_t cmd;
    result_t  result;

    mfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mfs_dp #(
        .LEVELS    (LEVELS),
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .in_kind      (s_tuser),
        .in_proc_id   (s_tdata[ID_W-1:0]),
        .in_svc_time  (s_tdata[ID_W+TIME_W-1:ID_W]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .result       (result)
    );

    assign m_tdata = {{(M_TDATA_W - RESULT_W){1'b0}}, result};

endmodule

@@ src/mfs_ram.sv @@
// ----------------------------------------------------------------------------
// mfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 48
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                  wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/mfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// mfs_ctrl
// Two-state controller: accept a transaction, then commit it into the
// output register once that register is free or being drained.
// ----------------------------------------------------------------------------
module mfs_ctrl
    import mfs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output mfs_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic stall;

    assign stall    = m_tvalid_reg && !m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Commands
    always_comb begin
        cmd.load   = s_tvalid && (state_reg == ST_IDLE);
        cmd.commit = (state_reg == ST_EXEC) && !stall;
    end

    // Next state and output valid
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

`include "multilevel_feedback_scheduler_core_assert.svh"

    `MFS_ASSERT_NEXT(a_commit_valid, cmd.commit, m_tvalid_reg, "commit did not raise m_tvalid")
    `MFS_ASSERT_NEXT(a_stall_holds, (state_reg == ST_EXEC) && stall, state_reg == ST_EXEC, "item dropped under stall")
    `MFS_ASSERT_NEXT(a_load_exec, cmd.load, state_reg == ST_EXEC, "accepted item not executed")

endmodule

@@ src/mfs_dp.sv @@
// ----------------------------------------------------------------------------
// mfs_dp
// Scheduler datapath: level FIFOs in RAM, head/fill pointers, held count,
// system time, slice arithmetic and the result register.
// ----------------------------------------------------------------------------
module mfs_dp
    import mfs_pkg::*;
#(
    parameter int LEVELS    = 3,
    parameter int MAX_PROCS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mfs_cmd_t            cmd,
    input  logic                in_kind,
    input  logic [ID_W-1:0]     in_proc_id,
    input  logic [TIME_W-1:0]   in_svc_time,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [BQ_W-1:0]     cfg_wdata,
    output result_t             result
);

    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int EW    = LW + 1;
    localparam int HW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int FW    = $clog2(MAX_PROCS + 1);
    localparam int DEPTH = LEVELS * MAX_PROCS;
    localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int QW    = BQ_W + LEVELS - 1;
    localparam int CW    = (QW > TIME_W) ? QW : TIME_W;
    localparam int SW    = FW + 1;

    // Configuration and scheduler state
    logic [BQ_W-1:0]    bq_reg;
    logic [LU_W-1:0]    lu_reg;
    logic [HW-1:0]      head_reg [LEVELS];
    logic [HW-1:0]      head_next [LEVELS];
    logic [FW-1:0]      fill_reg [LEVELS];
    logic [FW-1:0]      fill_next [LEVELS];
    logic [FW-1:0]      held_reg, held_next;
    logic [STIME_W-1:0] stime_reg, stime_next;

    // Captured item
    logic              kind_reg;
    logic [ID_W-1:0]   pid_reg;
    logic [TIME_W-1:0] need_in_reg;
    logic [LW-1:0]     lvl_reg;
    logic              found_reg;
    result_t           result_reg, result_next;

    // Level search on the fill counts
    logic [LW-1:0] lvl_sel;
    logic          found_sel;
    logic [AW-1:0] rd_addr;

    always_comb begin
        lvl_sel   = '0;
        found_sel = 1'b0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (fill_reg[l] != '0) begin
                lvl_sel   = LW'(l);
                found_sel = 1'b1;
            end
        end
        rd_addr = AW'(AW'(lvl_sel) * AW'(MAX_PROCS)) + AW'(head_reg[lvl_sel]);
    end

    // Queue RAM
    logic              ram_we;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_entry;
    logic [ENTRY_W-1:0] rd_data;

    mfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (cmd.load),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Slice arithmetic
    entry_t            ent;
    logic [BQ_W-1:0]   bq_eff;
    logic [QW-1:0]     quantum;
    logic [CW-1:0]     quant_c;
    logic              over;
    logic [TIME_W-1:0] used, need_after, run_new;
    logic [CNT_W-1:0]  cnt_new;
    logic              fin;
    logic [EW-1:0]     eff;
    logic [LW-1:0]     dst;
    logic [SW-1:0]     tail_sum;
    logic [HW-1:0]     tail;
    logic              admit_ok, disp_ok;

    always_comb begin
        ent     = entry_t'(rd_data);
        bq_eff  = (bq_reg == '0) ? BQ_W'(1) : bq_reg;
        quantum = QW'(bq_eff) << lvl_reg;
        quant_c = CW'(quantum);
        over    = CW'(ent.need) > quant_c;
        used    = over ? quant_c[TIME_W-1:0] : ent.need;
        need_after = over ? (ent.need - used) : '0;
        run_new = ent.run + used;
        cnt_new = (ent.cnt == CNT_MAX) ? CNT_MAX : (ent.cnt + CNT_W'(1));
        fin     = !over;

        // Effective number of levels, clamped to 1..LEVELS
        if (lu_reg == '0) begin
            eff = EW'(1);
        end else if (int'(lu_reg) > LEVELS) begin
            eff = EW'(LEVELS);
        end else begin
            eff = EW'(lu_reg);
        end

        admit_ok = (kind_reg == KIND_ADMIT) && (held_reg < FW'(MAX_PROCS));
        disp_ok  = (kind_reg == KIND_DISPATCH) && found_reg;

        // Destination level of the write
        if (kind_reg == KIND_ADMIT) begin
            dst = '0;
        end else if ((EW'(lvl_reg) + EW'(1)) < eff) begin
            dst = lvl_reg + LW'(1);
        end else begin
            dst = lvl_reg;
        end

        // Tail slot; same value before and after the pop on a requeue
        tail_sum = SW'(head_reg[dst]) + SW'(fill_reg[dst]);
        if (tail_sum >= SW'(MAX_PROCS)) begin
            tail_sum = tail_sum - SW'(MAX_PROCS);
        end
        tail = tail_sum[HW-1:0];

        wr_addr = AW'(AW'(dst) * AW'(MAX_PROCS)) + AW'(tail);
        ram_we  = cmd.commit && (admit_ok || (disp_ok && !fin));
        if (kind_reg == KIND_ADMIT) begin
            wr_entry = '{cnt: '0, run: '0, need: need_in_reg, id: pid_reg};
        end else begin
            wr_entry = '{cnt: cnt_new, run: run_new, need: need_after, id: ent.id};
        end
    end

    // State update
    always_comb begin
        held_next  = held_reg;
        stime_next = stime_reg;
        for (int l = 0; l < LEVELS; l++) begin
            head_next[l] = head_reg[l];
            fill_next[l] = fill_reg[l];
        end
        if (cmd.commit) begin
            if (admit_ok) begin
                held_next   = held_reg + FW'(1);
                fill_next[0] = fill_reg[0] + FW'(1);
            end
            if (disp_ok) begin
                stime_next = stime_reg + STIME_W'(used);
                head_next[lvl_reg] = (head_reg[lvl_reg] == HW'(MAX_PROCS - 1)) ?
                                     '0 : (head_reg[lvl_reg] + HW'(1));
                if (fin) begin
                    held_next = held_reg - FW'(1);
                    fill_next[lvl_reg] = fill_reg[lvl_reg] - FW'(1);
                end else if (dst != lvl_reg) begin
                    fill_next[lvl_reg] = fill_reg[lvl_reg] - FW'(1);
                    fill_next[dst]     = fill_reg[dst] + FW'(1);
                end
            end
        end
    end

    // Result assembly
    always_comb begin
        result_next = '0;
        if (kind_reg == KIND_ADMIT) begin
            result_next.served_id = pid_reg;
            if (admit_ok) begin
                result_next.accepted  = 1'b1;
                result_next.time_left = need_in_reg;
            end
        end else if (found_reg) begin
            result_next.accepted     = 1'b1;
            result_next.served_id    = ent.id;
            result_next.served_level = LVL_OUT_W'(lvl_reg);
            result_next.slice_start  = stime_reg;
            result_next.slice_used   = used;
            result_next.time_left    = need_after;
            result_next.total_run    = run_new;
            result_next.slice_count  = cnt_new;
            result_next.finished     = fin;
        end
        result_next.all_idle = (held_next == '0);
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bq_reg    <= BQ_RESET;
            lu_reg    <= LU_RESET;
            held_reg  <= '0;
            stime_reg <= '0;
            for (int l = 0; l < LEVELS; l++) begin
                head_reg[l] <= '0;
                fill_reg[l] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_BASE_QUANTUM:  bq_reg <= cfg_wdata;
                    REG_LEVELS_IN_USE: lu_reg <= cfg_wdata[LU_W-1:0];
                    default: ;
                endcase
            end
            held_reg  <= held_next;
            stime_reg <= stime_next;
            for (int l = 0; l < LEVELS; l++) begin
                head_reg[l] <= head_next[l];
                fill_reg[l] <= fill_next[l];
            end
        end
    end

    // Item capture and result payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= in_kind;
            pid_reg     <= in_proc_id;
            need_in_reg <= in_svc_time;
            lvl_reg     <= lvl_sel;
            found_reg   <= found_sel;
        end
        if (cmd.commit) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

`include "multilevel_feedback_scheduler_core_assert.svh"

    `MFS_ASSERT_ALWAYS(a_held_max, held_reg <= FW'(MAX_PROCS), "held count above capacity")
    `MFS_ASSERT_SAME(a_empty_dispatch, cmd.commit && (kind_reg == KIND_DISPATCH) && !found_reg, held_reg == '0, "no level found while processes held")
    `MFS_ASSERT_NEXT(a_admit_count, cmd.commit && admit_ok, held_reg == ($past(held_reg) + FW'(1)), "admit did not bump held count")

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multilevel feedback queue scheduler. Admit and
// dispatch transactions are streamed in with random gaps, and results are
// drained with random stalls. A per-item predictor keeps its own copy of
// the level FIFOs, the process count and the system clock. Each result is
// checked field by field against the predicted one.
// ----------------------------------------------------------------------------
module tb;
    import mfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_LVL       = 3;
    localparam int N_SLOT      = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 200;
    localparam int N_PHASES    = 8;

    typedef struct {
        logic              kind;
        logic [ID_W-1:0]   pid;
        logic [TIME_W-1:0] need;
    } job_item_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = KIND_ADMIT;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_index = REG_BASE_QUANTUM;
    logic [BQ_W-1:0]      cfg_wdata = '0;

    // Stimulus and scoreboard bookkeeping
    job_item_t job_q[$];
    result_t   slice_expect_q[$];
    int        jobs_queued   = 0;
    int        jobs_taken    = 0;
    int        errors        = 0;
    int        cycle_count   = 0;
    int        hold_requests = 0;
    int        hold_served   = 0;
    logic      s_quiet       = 1'b0;
    logic      m_quiet       = 1'b0;
    logic      s_took        = 1'b0;
    logic      m_took        = 1'b0;
    int        s_gap         = 0;
    int        m_stall       = 0;
    job_item_t drive_job;

    // Predictor state
    entry_t          q_store [N_LVL][N_SLOT];
    int              q_head  [N_LVL] = '{default: 0};
    int              q_fill  [N_LVL] = '{default: 0};
    int              held_procs      = 0;
    logic [31:0]     sched_clock     = '0;
    logic [BQ_W-1:0] cfg_quantum     = BQ_RESET;
    logic [LU_W-1:0] cfg_levels      = LU_RESET;

    multilevel_feedback_scheduler_core #(
        .LEVELS    (N_LVL),
        .MAX_PROCS (N_SLOT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 20 ns clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Append a process entry at the tail of a level
    function automatic void push_entry(int lvl, entry_t e);
        if (q_fill[lvl] < N_SLOT) begin
            q_store[lvl][(q_head[lvl] + q_fill[lvl]) % N_SLOT] = e;
            q_fill[lvl]++;
        end
    endfunction

    // Apply one admit or dispatch to the predictor and return its result
    function automatic result_t mlfq_schedule(logic kind, logic [ID_W-1:0] pid,
                                              logic [TIME_W-1:0] need_in);
        result_t r;
        entry_t  e;
        int      lvl;
        int      quantum;
        int      used;
        int      eff;
        int      waiting;
        logic    found;
        r     = '0;
        lvl   = 0;
        found = 1'b0;
        if (kind == KIND_ADMIT) begin
            r.served_id = pid;
            if (held_procs < N_SLOT) begin
                e      = '0;
                e.id   = pid;
                e.need = need_in;
                push_entry(0, e);
                held_procs++;
                r.accepted  = 1'b1;
                r.time_left = need_in;
            end
        end else begin
            // lowest-numbered non-empty level wins
            for (int l = N_LVL - 1; l >= 0; l--) begin
                if (q_fill[l] != 0) begin
                    found = 1'b1;
                    lvl   = l;
                end
            end
            if (found) begin
                e       = q_store[lvl][q_head[lvl]];
                quantum = ((cfg_quantum == 0) ? 1 : int'(cfg_quantum)) << lvl;
                r.slice_start = sched_clock;
                q_head[lvl] = (q_head[lvl] + 1) % N_SLOT;
                q_fill[lvl]--;
                if (int'(e.need) > quantum) begin
                    used   = quantum;
                    e.need = e.need - used[TIME_W-1:0];
                    r.finished = 1'b0;
                end else begin
                    used   = int'(e.need);
                    e.need = '0;
                    r.finished = 1'b1;
                end
                e.run = e.run + used[TIME_W-1:0];
                if (e.cnt != CNT_MAX)
                    e.cnt++;
                sched_clock = sched_clock + used;
                if (r.finished) begin
                    if (held_procs != 0)
                        held_procs--;
                end else begin
                    // demote, or round robin on the last level in use
                    eff = (cfg_levels == 0) ? 1 : int'(cfg_levels);
                    if (eff > N_LVL)
                        eff = N_LVL;
                    push_entry((lvl + 1 < eff) ? lvl + 1 : lvl, e);
                end
                r.accepted     = 1'b1;
                r.served_id    = e.id;
                r.served_level = lvl[LVL_OUT_W-1:0];
                r.slice_used   = used[TIME_W-1:0];
                r.time_left    = e.need;
                r.total_run    = e.run;
                r.slice_count  = e.cnt;
            end
        end
        waiting = 0;
        for (int l = 0; l < N_LVL; l++)
            waiting += q_fill[l];
        r.all_idle = (waiting == 0);
        return r;
    endfunction

    // Field by field comparison of one result transaction
    task automatic check_result(input result_t want, input result_t got);
        string       label [10];
        logic [31:0] exp_v [10];
        logic [31:0] act_v [10];
        label = '{"accepted", "served_id", "served_level", "slice_start", "slice_used",
                  "time_left", "total_run", "slice_count", "finished", "all_idle"};
        exp_v = '{32'(want.accepted), 32'(want.served_id), 32'(want.served_level),
                  32'(want.slice_start), 32'(want.slice_used), 32'(want.time_left),
                  32'(want.total_run), 32'(want.slice_count), 32'(want.finished),
                  32'(want.all_idle)};
        act_v = '{32'(got.accepted), 32'(got.served_id), 32'(got.served_level),
                  32'(got.slice_start), 32'(got.slice_used), 32'(got.time_left),
                  32'(got.total_run), 32'(got.slice_count), 32'(got.finished),
                  32'(got.all_idle)};
        for (int i = 0; i < 10; i++) begin
            if (act_v[i] !== exp_v[i]) begin
                $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
                         $time, label[i], exp_v[i], act_v[i]);
                errors++;
            end
        end
    endtask

    // Monitor: register writes, result checks, input transactions, watchdog
    always @(posedge aclk) begin
        result_t got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        s_took <= s_tvalid && s_tready;
        m_took <= m_tvalid && m_tready;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BASE_QUANTUM:  cfg_quantum = cfg_wdata;
                    REG_LEVELS_IN_USE: cfg_levels  = cfg_wdata[LU_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (slice_expect_q.size() == 0) begin
                    $display("%0t: result with none expected, actual 0x%0h", $time, got);
                    errors++;
                end else begin
                    check_result(slice_expect_q.pop_front(), got);
                end
            end
            if (s_tvalid && s_tready) begin
                slice_expect_q.insert(slice_expect_q.size(),
                                      mlfq_schedule(s_tuser, s_tdata[ID_W-1:0],
                                                    s_tdata[ID_W+TIME_W-1:ID_W]));
                jobs_taken++;
            end
        end
    end

    // Driver: feeds pending items, random gap after each transaction
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_took)) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (job_q.size() != 0) begin
                drive_job = job_q.pop_front();
                s_tuser  <= drive_job.kind;
                s_tdata  <= {{(S_TDATA_W - ID_W - TIME_W){1'b0}}, drive_job.need, drive_job.pid};
                s_tvalid <= 1'b1;
                s_gap = s_quiet ? 0 : $urandom_range(0, 16);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall per result, long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_served != hold_requests) begin
                hold_served++;
                m_stall = LONG_HOLD;
            end else if (m_took) begin
                m_stall = m_quiet ? 0 : $urandom_range(0, 16);
            end
            if (m_stall > 0) begin
                m_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_job(input logic kind, input logic [ID_W-1:0] pid,
                             input logic [TIME_W-1:0] need);
        job_item_t j;
        j.kind = kind;
        j.pid  = pid;
        j.need = need;
        job_q.insert(job_q.size(), j);
        jobs_queued++;
    endtask

    // Every item taken and every result checked
    task automatic wait_drained();
        while (jobs_taken != jobs_queued || slice_expect_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [BQ_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random mix of admits and dispatches, needs scaled to the quantum
    task automatic random_jobs(input int count, input int admit_pct, input int bq_eff);
        logic              kind;
        logic [TIME_W-1:0] need;
        int                cap;
        cap = (bq_eff * 6 > 4095) ? 4095 : bq_eff * 6;
        for (int i = 0; i < count; i++) begin
            kind = ($urandom_range(0, 99) < admit_pct) ? KIND_ADMIT : KIND_DISPATCH;
            case ($urandom_range(0, 7))
                0:       need = TIME_W'($urandom_range(0, 4095));
                1, 2:    need = TIME_W'($urandom_range(1, bq_eff));
                default: need = TIME_W'($urandom_range(1, cap));
            endcase
            queue_job(kind, ID_W'($urandom_range(0, 255)), need);
        end
    endtask

    // Test sequence
    initial begin
        int ph_bq    [N_PHASES] = '{255, 0, 200, 7, 100, 1, 20, 13};
        int ph_lu    [N_PHASES] = '{3, 1, 2, 0, 3, 2, 3, 1};
        int ph_admit [N_PHASES] = '{45, 45, 30, 45, 30, 45, 45, 45};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty dispatch, need extremes, exact quantum, demotion,
        // round robin at the last level, then a full block and a rejection
        queue_job(KIND_DISPATCH, 8'hC3, 12'hFFF);
        queue_job(KIND_ADMIT, 8'h00, 12'd0);
        queue_job(KIND_ADMIT, 8'hFF, 12'hFFF);
        queue_job(KIND_ADMIT, 8'hA5, 12'd20);
        queue_job(KIND_ADMIT, 8'h5A, 12'd21);
        repeat (7)
            queue_job(KIND_DISPATCH, 8'h00, 12'h000);
        for (int i = 1; i <= 16; i++)
            queue_job(KIND_ADMIT, 8'(i * 15), 12'(i * 3));
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            repeat (4) @(negedge aclk);
            write_reg(REG_BASE_QUANTUM, ph_bq[p][BQ_W-1:0]);
            write_reg(REG_LEVELS_IN_USE, ph_lu[p][BQ_W-1:0]);
            s_quiet = (p == 2 || p == 4 || p == 6);
            m_quiet = (p == 4 || p == 5);
            // long receiver hold-off while the sender keeps offering
            if (p == 2 || p == 6)
                hold_requests++;
            random_jobs(230, ph_admit[p], (ph_bq[p] == 0) ? 1 : ph_bq[p]);
        end

        wait_drained();
        repeat (8) @(negedge aclk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/mfs_pkg.sv
src/mfs_ram.sv
src/mfs_ctrl.sv
src/mfs_dp.sv
src/multilevel_feedback_scheduler_core.sv
tb/sv/tb.sv
